/* rtl/core/cbpe_pkg.sv */
// ----------------------------------------------------------------------------
// cbpe_pkg: shared types and constants for the cubic Bezier point evaluator
// Coordinate format, configuration register map and register reset values.
// ----------------------------------------------------------------------------
package cbpe_pkg;

	localparam int COORD_W   = 16;
	localparam int PARAM_W   = 17;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_IDX_W = 8;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_P0_X = 3'd0,
		REG_P0_Y = 3'd1,
		REG_P1_X = 3'd2,
		REG_P1_Y = 3'd3,
		REG_P2_X = 3'd4,
		REG_P2_Y = 3'd5,
		REG_P3_X = 3'd6,
		REG_P3_Y = 3'd7
	} reg_idx_t;

	localparam coord_t REG_RESET [NUM_REGS] = '{
		16'sd1600, 16'sd6400, 16'sd2400, 16'sd7200,
		16'sd4000, 16'sd5600, 16'sd4800, 16'sd6400
	};

endpackage

/* rtl/core/cbpe_weights.sv */
// ----------------------------------------------------------------------------
// cbpe_weights: Bernstein weight pipeline
// Stage 1 clamps t and forms s = 1 - t, stage 2 squares, stage 3 forms the
// cubic terms. Middle weights leave without their factor of three.
// ----------------------------------------------------------------------------
module cbpe_weights #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [cbpe_pkg::PARAM_W-1:0] curve_param,
	output logic                         out_valid,
	output logic [FRAC_BITS:0]           weight [4]
);

	localparam int TW = FRAC_BITS + 1;
	localparam int CW = (TW > cbpe_pkg::PARAM_W) ? TW : cbpe_pkg::PARAM_W;
	localparam logic [CW-1:0]   ONE_C = CW'(1) << FRAC_BITS;
	localparam logic [TW-1:0]   ONE_T = TW'(1) << FRAC_BITS;
	localparam logic [2*TW-1:0] HALF  = (2*TW)'(1) << (FRAC_BITS - 1);

	// rounded product of two values no larger than one
	function automatic logic [TW-1:0] rnd_mul(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [2*TW-1:0] p;
		p = (2*TW)'(a) * (2*TW)'(b) + HALF;
		return p[FRAC_BITS+TW-1:FRAC_BITS];
	endfunction

	logic [CW-1:0] t_ext;
	logic [CW-1:0] t_cl;

	logic          v_s1, v_s2, v_s3;
	logic [TW-1:0] t_s1, s_s1;
	logic [TW-1:0] t_s2, s_s2, tt_s2, ss_s2;
	logic [TW-1:0] w_s3 [4];

	always_comb begin
		t_ext = CW'(curve_param);
		t_cl  = (t_ext > ONE_C) ? ONE_C : t_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= t_cl[TW-1:0];
		s_s1    <= ONE_T - t_cl[TW-1:0];
		t_s2    <= t_s1;
		s_s2    <= s_s1;
		tt_s2   <= rnd_mul(t_s1, t_s1);
		ss_s2   <= rnd_mul(s_s1, s_s1);
		w_s3[0] <= rnd_mul(ss_s2, s_s2);
		w_s3[1] <= rnd_mul(ss_s2, t_s2);
		w_s3[2] <= rnd_mul(tt_s2, s_s2);
		w_s3[3] <= rnd_mul(tt_s2, t_s2);
	end

	assign out_valid = v_s3;
	assign weight    = w_s3;

endmodule

/* rtl/core/cubic_bezier_point_evaluator_core.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_point_evaluator_core: cubic Bezier point from curve parameter t
// Path: the start transfer moves through every stage below to the done strobe.
// Throughput: one t per cycle; busy stays low, the receiver takes every result.
// Stages: three weight stages, point multiply, weighted sum, round/saturate.
// Reset: valid bits clear; control points return to their default curve.
// ----------------------------------------------------------------------------
module cubic_bezier_point_evaluator_core #(
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [cbpe_pkg::PARAM_W-1:0]   curve_param,
	output logic                           done,
	output cbpe_pkg::coord_t               point_x,
	output cbpe_pkg::coord_t               point_y,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cbpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbpe_pkg::COORD_W-1:0]   cfg_data
);

	localparam int TW = PARAM_FRAC_BITS + 1;
	localparam int PW = TW + 1 + cbpe_pkg::COORD_W;
	localparam int AW = PW + 3;
	localparam int CW = (TW > cbpe_pkg::PARAM_W) ? TW : cbpe_pkg::PARAM_W;
	localparam logic [CW-1:0]        ONE_C  = CW'(1) << PARAM_FRAC_BITS;
	localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (PARAM_FRAC_BITS - 1);
	localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
	localparam logic signed [AW-1:0] SAT_LO = AW'(-32768);

	cbpe_pkg::coord_t regs_q [cbpe_pkg::NUM_REGS];

	logic          w_valid;
	logic [TW-1:0] weight [4];

	logic                 v_s4, v_s5, v_s6;
	logic signed [PW-1:0] m_s4 [2][4];
	logic signed [AW-1:0] acc_s5 [2];
	cbpe_pkg::coord_t     pt_s6 [2];

	logic signed [AW-1:0] acc_d [2];
	logic signed [AW-1:0] mid_d [2];
	logic signed [AW-1:0] q_d   [2];
	cbpe_pkg::coord_t     sat_d [2];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// index beyond the register map is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= cbpe_pkg::REG_RESET;
		end else if (cfg_valid && cfg_ready && (cfg_index < cbpe_pkg::CFG_IDX_W'(cbpe_pkg::NUM_REGS))) begin
			regs_q[cfg_index[cbpe_pkg::REG_IDX_W-1:0]] <= cfg_data;
		end
	end

	cbpe_weights #(
		.FRAC_BITS (PARAM_FRAC_BITS)
	) u_weights (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.curve_param (curve_param),
		.out_valid   (w_valid),
		.weight      (weight)
	);

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			// middle terms carry the binomial factor 3
			mid_d[c] = AW'(m_s4[c][1]) + AW'(m_s4[c][2]);
			acc_d[c] = AW'(m_s4[c][0]) + AW'(m_s4[c][3]) + (mid_d[c] <<< 1) + mid_d[c];
			q_d[c]   = (acc_s5[c] + HALF_A) >>> PARAM_FRAC_BITS;
			if (q_d[c] > SAT_HI) begin
				sat_d[c] = cbpe_pkg::coord_t'(SAT_HI[cbpe_pkg::COORD_W-1:0]);
			end else if (q_d[c] < SAT_LO) begin
				sat_d[c] = cbpe_pkg::coord_t'(SAT_LO[cbpe_pkg::COORD_W-1:0]);
			end else begin
				sat_d[c] = cbpe_pkg::coord_t'(q_d[c][cbpe_pkg::COORD_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= w_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			m_s4[0][i] <= $signed({1'b0, weight[i]}) * PW'(regs_q[2*i]);
			m_s4[1][i] <= $signed({1'b0, weight[i]}) * PW'(regs_q[2*i+1]);
		end
		for (int c = 0; c < 2; c++) begin
			acc_s5[c] <= acc_d[c];
			pt_s6[c]  <= sat_d[c];
		end
	end

	assign done    = v_s6;
	assign point_x = pt_s6[0];
	assign point_y = pt_s6[1];

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("done without a start transfer six cycles earlier");

	a_t_zero_is_p0: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(curve_param == '0, 6)) |->
		(point_x == regs_q[cbpe_pkg::REG_P0_X] && point_y == regs_q[cbpe_pkg::REG_P0_Y]))
		else $error("t = 0 did not return the first control point");

	a_t_one_is_p3: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(CW'(curve_param) >= ONE_C, 6)) |->
		(point_x == regs_q[cbpe_pkg::REG_P3_X] && point_y == regs_q[cbpe_pkg::REG_P3_Y]))
		else $error("t at or above one did not return the last control point");

endmodule
